// File: design/local_minimum_counter_top_defines.svh
// ----------------------------------------------------------------------------
// Local minimum counter assertion macros
// Concurrent assertion helpers used by the top-level design file. Simulation builds
// get the checks; synthesis builds get empty bodies.
// ----------------------------------------------------------------------------
`ifndef LOCAL_MINIMUM_COUNTER_TOP_DEFINES_SVH
`define LOCAL_MINIMUM_COUNTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define LMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every clock edge, reset included.
`define LMC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define LMC_ASSERT(lbl, prop, msg)
`define LMC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: design/lmc_pkg.sv
// ----------------------------------------------------------------------------
// Local minimum counter package
// Sizes, types and register indexes shared by the local minimum counter.
// ----------------------------------------------------------------------------
package lmc_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 1024;
  localparam int VALUE_BITS   = 16;
  localparam int COL_BITS     = $clog2(MAX_WIDTH);
  localparam int ROW_BITS     = $clog2(MAX_HEIGHT);
  localparam int SIZE_BITS    = 11;
  localparam int COUNT_BITS   = 19;
  localparam int CFG_IDX_BITS = 2;
  localparam int LINE_BITS    = 2 * VALUE_BITS;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [COL_BITS-1:0]   col_t;
  typedef logic [ROW_BITS-1:0]   row_t;
  typedef logic [SIZE_BITS-1:0]  size_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [LINE_BITS-1:0]  line_t;

  localparam size_t  WIDTH_MAX_S  = size_t'(MAX_WIDTH);
  localparam size_t  HEIGHT_MAX_S = size_t'(MAX_HEIGHT);
  localparam col_t   COL_LAST_MAX = col_t'(MAX_WIDTH - 1);
  localparam row_t   ROW_LAST_MAX = row_t'(MAX_HEIGHT - 1);
  localparam count_t COUNT_MAX    = '1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT
  } cfg_reg_e;

  // Position flags of an element, carried from the address stage to the
  // compute stage.
  typedef struct packed {
    logic last;   // last element of the frame
    logic c_end;  // last column
    logic r_end;  // last row
    logic r_ge1;
    logic r_ge2;
    logic c_ge1;
    logic c_ge2;
  } s1_ctl_t;

endpackage

// File: design/lmc_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: design/local_minimum_counter_top.sv
// ----------------------------------------------------------------------------
// Local minimum counter
// Counts strict local minima (3x3 neighbourhood) of a raster-streamed matrix.
// ----------------------------------------------------------------------------
// Usage:
// Elements enter in row-major order on the input channel (in_valid_i,
// in_stall_o, element_value_i), one per cycle while not stalled. The frame
// size comes from two registers on the configuration channel: index 0 is
// the width, index 1 the height, both clamped to 1..1024. Any such write
// restarts the frame. One result (minimum_count_o) leaves on the output
// channel per frame, registered when its last element is in the compute stage.
// Throughput is one element per cycle unless stalled, set by the single
// line-buffer RAM: it is read in the address stage and written back in the
// compute stage, with the written word forwarded when the next element hits
// the same column. A frame's last element is held off only while an earlier
// result still waits in the output register or is about to enter it.
// Reset clears position, count and output state at once; the line buffer
// needs no clearing pass. When the receiver stalls, the result stays put and
// streaming continues until the next frame's last element.
// ----------------------------------------------------------------------------
`include "local_minimum_counter_top_defines.svh"

module local_minimum_counter_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  lmc_pkg::value_t                      element_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output lmc_pkg::count_t                      minimum_count_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [lmc_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  lmc_pkg::size_t                       cfg_data_i
);

  // Address stage state.
  lmc_pkg::col_t    col_q, col_d;
  lmc_pkg::row_t    row_q, row_d;
  lmc_pkg::col_t    w_last_q, w_last_d;
  lmc_pkg::row_t    h_last_q, h_last_d;

  // Compute stage.
  logic             s1_valid_q;
  lmc_pkg::s1_ctl_t s1_ctl_q, s1_ctl_d;
  lmc_pkg::col_t    s1_col_q;
  lmc_pkg::value_t  s1_val_q;
  logic             fwd_q, fwd_d;
  lmc_pkg::line_t   fwd_data_q;
  lmc_pkg::count_t  count_q, count_d;

  // Window columns 0 and 1 (rows top, middle, bottom).
  lmc_pkg::value_t  win1_q [3];
  lmc_pkg::value_t  win2_q [3];

  // Output register.
  logic             out_valid_q, out_valid_d;
  lmc_pkg::count_t  out_count_q;

  logic             in_accept;
  logic             frame_last_now;
  logic             cfg_write;
  logic             cfg_restart;
  lmc_pkg::size_t   data_m1;
  lmc_pkg::line_t   ram_rdata;
  lmc_pkg::line_t   line_word;
  lmc_pkg::line_t   wb_word;

  lmc_pkg::value_t  t0, t1, t2, m0, m1, m2, b0, b1, b2;
  logic             hit_a, hit_b, hit_c, hit_d;
  logic [2:0]       n_hits;
  logic [lmc_pkg::COUNT_BITS:0] sum_ext;
  lmc_pkg::count_t  count_sat;

  function automatic logic below(lmc_pkg::value_t c, lmc_pkg::value_t n, logic ok);
    return !ok || (c < n);
  endfunction

  // ---------------------------------------------------------------- handshake
  assign frame_last_now = (col_q == w_last_q) && (row_q == h_last_q);
  assign in_stall_o     = frame_last_now &&
                          ((out_valid_q && out_stall_i) || (s1_valid_q && s1_ctl_q.last));
  assign in_accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o    = 1'b1;
  assign cfg_write      = cfg_valid_i && cfg_ready_o;
  assign out_valid_o    = out_valid_q;
  assign minimum_count_o = out_count_q;

  // ------------------------------------------------------------ configuration
  assign data_m1 = cfg_data_i - lmc_pkg::size_t'(1);

  always_comb begin
    w_last_d    = w_last_q;
    h_last_d    = h_last_q;
    cfg_restart = 1'b0;
    if (cfg_write) begin
      case (cfg_index_i)
        lmc_pkg::REG_FRAME_WIDTH: begin
          cfg_restart = 1'b1;
          if (cfg_data_i == '0) begin
            w_last_d = '0;
          end else if (cfg_data_i > lmc_pkg::WIDTH_MAX_S) begin
            w_last_d = lmc_pkg::COL_LAST_MAX;
          end else begin
            w_last_d = data_m1[lmc_pkg::COL_BITS-1:0];
          end
        end
        lmc_pkg::REG_FRAME_HEIGHT: begin
          cfg_restart = 1'b1;
          if (cfg_data_i == '0) begin
            h_last_d = '0;
          end else if (cfg_data_i > lmc_pkg::HEIGHT_MAX_S) begin
            h_last_d = lmc_pkg::ROW_LAST_MAX;
          end else begin
            h_last_d = data_m1[lmc_pkg::ROW_BITS-1:0];
          end
        end
        default: begin
          cfg_restart = 1'b0;
        end
      endcase
    end
  end

  // ------------------------------------------------------------ address stage
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_restart) begin
      col_d = '0;
      row_d = '0;
    end else if (in_accept) begin
      if (col_q == w_last_q) begin
        col_d = '0;
        row_d = (row_q == h_last_q) ? '0 : row_q + lmc_pkg::row_t'(1);
      end else begin
        col_d = col_q + lmc_pkg::col_t'(1);
      end
    end
  end

  always_comb begin
    s1_ctl_d.last  = frame_last_now;
    s1_ctl_d.c_end = col_q == w_last_q;
    s1_ctl_d.r_end = row_q == h_last_q;
    s1_ctl_d.r_ge1 = row_q != '0;
    s1_ctl_d.r_ge2 = row_q > lmc_pkg::row_t'(1);
    s1_ctl_d.c_ge1 = col_q != '0;
    s1_ctl_d.c_ge2 = col_q > lmc_pkg::col_t'(1);
  end

  // The previous element writes its column back in the same cycle this one
  // reads; with a one-column frame that is the same entry.
  assign fwd_d = in_accept && s1_valid_q && (s1_col_q == col_q);

  // Each entry holds {upper row, middle row} for its column.
  lmc_ram #(
    .WIDTH (lmc_pkg::LINE_BITS),
    .DEPTH (lmc_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (wb_word),
    .re_i    (in_accept),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  // ------------------------------------------------------------ compute stage
  assign line_word = fwd_q ? fwd_data_q : ram_rdata;
  assign t2 = line_word[lmc_pkg::LINE_BITS-1:lmc_pkg::VALUE_BITS];
  assign m2 = line_word[lmc_pkg::VALUE_BITS-1:0];
  assign b2 = s1_val_q;
  assign t1 = win2_q[0];
  assign m1 = win2_q[1];
  assign b1 = win2_q[2];
  assign t0 = win1_q[0];
  assign m0 = win1_q[1];
  assign b0 = win1_q[2];
  assign wb_word = {m2, b2};

  always_comb begin
    // Middle-row element one column back.
    hit_a = s1_ctl_q.r_ge1 && s1_ctl_q.c_ge1 &&
            below(m1, t0, s1_ctl_q.r_ge2 && s1_ctl_q.c_ge2) &&
            below(m1, t1, s1_ctl_q.r_ge2) &&
            below(m1, t2, s1_ctl_q.r_ge2) &&
            below(m1, m0, s1_ctl_q.c_ge2) &&
            below(m1, m2, 1'b1) &&
            below(m1, b0, s1_ctl_q.c_ge2) &&
            below(m1, b1, 1'b1) &&
            below(m1, b2, 1'b1);
    // Middle-row element in the last column.
    hit_b = s1_ctl_q.r_ge1 && s1_ctl_q.c_end &&
            below(m2, t1, s1_ctl_q.r_ge2 && s1_ctl_q.c_ge1) &&
            below(m2, t2, s1_ctl_q.r_ge2) &&
            below(m2, m1, s1_ctl_q.c_ge1) &&
            below(m2, b1, s1_ctl_q.c_ge1) &&
            below(m2, b2, 1'b1);
    // Bottom-row elements of the frame's last row have no row below, so they
    // are judged as they stream in rather than after the frame ends.
    hit_c = s1_ctl_q.r_end && s1_ctl_q.c_ge1 &&
            below(b1, m0, s1_ctl_q.r_ge1 && s1_ctl_q.c_ge2) &&
            below(b1, m1, s1_ctl_q.r_ge1) &&
            below(b1, m2, s1_ctl_q.r_ge1) &&
            below(b1, b0, s1_ctl_q.c_ge2) &&
            below(b1, b2, 1'b1);
    hit_d = s1_ctl_q.last &&
            below(b2, m1, s1_ctl_q.r_ge1 && s1_ctl_q.c_ge1) &&
            below(b2, m2, s1_ctl_q.r_ge1) &&
            below(b2, b1, s1_ctl_q.c_ge1);
  end

  assign n_hits  = 3'(hit_a) + 3'(hit_b) + 3'(hit_c) + 3'(hit_d);
  assign sum_ext = {1'b0, count_q} + {{(lmc_pkg::COUNT_BITS - 2){1'b0}}, n_hits};
  assign count_sat = (sum_ext > {1'b0, lmc_pkg::COUNT_MAX}) ?
                     lmc_pkg::COUNT_MAX : sum_ext[lmc_pkg::COUNT_BITS-1:0];

  always_comb begin
    count_d = count_q;
    if (cfg_restart) begin
      count_d = '0;
    end else if (s1_valid_q) begin
      count_d = s1_ctl_q.last ? '0 : count_sat;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_valid_q && s1_ctl_q.last) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      w_last_q    <= '0;
      h_last_q    <= '0;
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      w_last_q    <= w_last_d;
      h_last_q    <= h_last_d;
      s1_valid_q  <= in_accept;
      fwd_q       <= fwd_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_ctl_q   <= s1_ctl_d;
      s1_col_q   <= col_q;
      s1_val_q   <= element_value_i;
      fwd_data_q <= wb_word;
    end
    if (s1_valid_q) begin
      win1_q    <= win2_q;
      win2_q[0] <= t2;
      win2_q[1] <= m2;
      win2_q[2] <= b2;
    end
    if (s1_valid_q && s1_ctl_q.last) begin
      out_count_q <= count_sat;
    end
  end

  // --------------------------------------------------------------- assertions
  `LMC_ASSERT(a_result_slot_free,
              (s1_valid_q && s1_ctl_q.last) |-> (!out_valid_q || !out_stall_i),
              "frame result reached a full output register")
  `LMC_ASSERT(a_pos_in_frame,
              (col_q <= w_last_q) && (row_q <= h_last_q),
              "stream position outside the configured frame")
  `LMC_ASSERT(a_fwd_needs_item,
              fwd_q |-> s1_valid_q,
              "line buffer forwarding without an element in the compute stage")
  `LMC_ASSERT(a_count_restarts,
              (s1_valid_q && s1_ctl_q.last) |=> (count_q == '0),
              "running count not cleared after a frame")
  `LMC_ASSERT_ALWAYS(a_reset_idle,
                     !rst_ni |-> (!out_valid_o && !s1_valid_q),
                     "pipeline not idle in reset")

endmodule

// File: bench/tb_local_minimum_counter_top.sv
// ----------------------------------------------------------------------------
// Local minimum counter testbench
// Streams frames of elements through the block under several frame sizes and
// handshake patterns. A behavioral predictor counts the strict 3x3 minima of
// every completed frame and each returned count is compared in order.
// ----------------------------------------------------------------------------
module tb_local_minimum_counter_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;

  // The two upper register indexes are unused by the block.
  localparam logic [lmc_pkg::CFG_IDX_BITS-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [lmc_pkg::CFG_IDX_BITS-1:0] REG_SPARE_HI = 2'd3;

  typedef enum int {SPREAD_FULL, SPREAD_LOW, SPREAD_HIGH} spread_e;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_stall_o;
  lmc_pkg::value_t                  element_value_i;
  logic                             out_valid_o;
  logic                             out_stall_i;
  lmc_pkg::count_t                  minimum_count_o;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [lmc_pkg::CFG_IDX_BITS-1:0] cfg_index_i;
  lmc_pkg::size_t                   cfg_data_i;

  // Predictor state.
  lmc_pkg::size_t  width_reg;
  lmc_pkg::size_t  height_reg;
  lmc_pkg::value_t frame_elems[$];
  lmc_pkg::count_t expected_counts[$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles_left;
  int cycle_count;
  int mismatch_count;

  local_minimum_counter_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .element_value_i(element_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .minimum_count_o(minimum_count_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Long receiver hold-off, counted down here once a test arms it.
  always @(posedge clk_i) begin
    if (hold_cycles_left > 0) hold_cycles_left <= hold_cycles_left - 1;
  end

  always @(posedge clk_i) begin
    out_stall_i <= (hold_cycles_left > 0) || ($urandom_range(99) < recv_stall_pct);
  end

  function automatic int clamp_dim(input lmc_pkg::size_t v, input int maxv);
    if (v == 0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic lmc_pkg::count_t count_frame_minima(input int w, input int h);
    int              tally;
    int              nr;
    int              nc;
    bit              is_min;
    lmc_pkg::value_t centre;
    tally = 0;
    for (int rr = 0; rr < h; rr++) begin
      for (int cc = 0; cc < w; cc++) begin
        centre = frame_elems[rr * w + cc];
        is_min = 1'b1;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            nr = rr + dr;
            nc = cc + dc;
            if ((dr != 0 || dc != 0) && nr >= 0 && nr < h && nc >= 0 && nc < w) begin
              if (!(centre < frame_elems[nr * w + nc])) is_min = 1'b0;
            end
          end
        end
        if (is_min) tally++;
      end
    end
    if (tally > int'(lmc_pkg::COUNT_MAX)) tally = int'(lmc_pkg::COUNT_MAX);
    return lmc_pkg::count_t'(tally);
  endfunction

  function automatic void note_element(input lmc_pkg::value_t v);
    int w;
    int h;
    w = clamp_dim(width_reg, lmc_pkg::MAX_WIDTH);
    h = clamp_dim(height_reg, lmc_pkg::MAX_HEIGHT);
    frame_elems.push_back(v);
    if (frame_elems.size() == w * h) begin
      expected_counts.push_back(count_frame_minima(w, h));
      frame_elems.delete();
    end
  endfunction

  // A size write drops the frame in progress; the spare indexes do nothing.
  function automatic void note_register_write(
      input logic [lmc_pkg::CFG_IDX_BITS-1:0] idx, input lmc_pkg::size_t data);
    if (idx == lmc_pkg::REG_FRAME_WIDTH) begin
      width_reg = data;
      frame_elems.delete();
    end else if (idx == lmc_pkg::REG_FRAME_HEIGHT) begin
      height_reg = data;
      frame_elems.delete();
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : check_counts
    lmc_pkg::count_t want_count;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_counts.size() == 0) begin
        report_mismatch($sformatf("count %0d with no frame pending", minimum_count_o));
      end else begin
        want_count = expected_counts.pop_front();
        if (minimum_count_o !== want_count)
          report_mismatch($sformatf("minimum_count %0d, predicted %0d",
                                    minimum_count_o, want_count));
      end
    end
  end

  // Valid stays high across back-to-back elements; it drops only for a gap.
  task automatic send_element(input lmc_pkg::value_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    element_value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    note_element(v);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_counts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [lmc_pkg::CFG_IDX_BITS-1:0] idx,
                                input lmc_pkg::size_t data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    note_register_write(idx, data);
  endtask

  task automatic set_frame_size(input lmc_pkg::size_t w, input lmc_pkg::size_t h);
    drain_results();
    write_register(lmc_pkg::REG_FRAME_WIDTH, w);
    write_register(lmc_pkg::REG_FRAME_HEIGHT, h);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic lmc_pkg::value_t pick_value(input spread_e spread);
    case (spread)
      SPREAD_LOW:  return lmc_pkg::value_t'($urandom_range(3));
      SPREAD_HIGH: return lmc_pkg::value_t'($urandom_range(65535, 65532));
      default:     return lmc_pkg::value_t'($urandom_range(65535));
    endcase
  endfunction

  task automatic send_values(input int n, input spread_e spread);
    repeat (n) send_element(pick_value(spread));
  endtask

  // Out of reset the frame is a single element, so every element is a minimum.
  task automatic test_reset_size();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_element(16'h0000);
    send_element(16'hFFFF);
  endtask

  task automatic test_directed_cases();
    // Interior minimum surrounded by ties among the border elements.
    set_frame_size(11'd3, 11'd3);
    send_element(16'd5); send_element(16'd5); send_element(16'd5);
    send_element(16'd5); send_element(16'd0); send_element(16'd5);
    send_element(16'd5); send_element(16'd5); send_element(16'd5);
    // Single column: equal vertical neighbours do not count.
    set_frame_size(11'd1, 11'd3);
    send_element(16'd7); send_element(16'd7); send_element(16'd3);
    // Single row with both value extremes.
    set_frame_size(11'd3, 11'd1);
    send_element(16'hFFFF); send_element(16'h0000); send_element(16'hFFFF);
    // A size of zero behaves as one.
    set_frame_size(11'd0, 11'd0);
    send_element(16'd42);
    // A size write in the middle of a frame abandons it without a count.
    set_frame_size(11'd2, 11'd2);
    send_element(16'd1); send_element(16'd2); send_element(16'd3);
    set_frame_size(11'd2, 11'd1);
    send_element(16'd8); send_element(16'd8);
    // Writes to the spare indexes leave the frame in progress alone.
    send_element(16'd9);
    drain_results();
    write_register(REG_SPARE_LO, 11'h7FF);
    write_register(REG_SPARE_HI, 11'h000);
    cfg_valid_i <= 1'b0;
    send_element(16'd4);
  endtask

  // Oversized registers clamp to the largest frame; the partial frame sent
  // under them is dropped by the next size write.
  task automatic test_size_clamping();
    send_idle_pct  = 23;
    recv_stall_pct = 23;
    set_frame_size(11'h7FF, 11'd1100);
    send_values(20, SPREAD_FULL);
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                  input int item_goal);
    int sent;
    int w;
    int h;
    int n;
    sent           = 0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent < item_goal) begin
      if ($urandom_range(7) == 0) begin
        w = $urandom_range(40, 1);
        h = $urandom_range(3, 1);
      end else begin
        w = $urandom_range(8, 1);
        h = $urandom_range(8, 1);
      end
      set_frame_size(lmc_pkg::size_t'(w), lmc_pkg::size_t'(h));
      repeat ($urandom_range(3, 1)) begin
        send_values(w * h, spread_e'($urandom_range(2)));
        sent += w * h;
      end
      // Now and then leave a partial frame for the next size write to drop.
      if (w * h > 1 && $urandom_range(5) == 0) begin
        n = $urandom_range(w * h - 1, 1);
        send_values(n, SPREAD_FULL);
        sent += n;
      end
    end
  endtask

  task automatic test_random_frames();
    run_random_phase(0, 0, 64);
    run_random_phase(63, 0, 64);
    run_random_phase(0, 63, 64);
    run_random_phase(23, 23, 64);
  endtask

  // The receiver holds off while small frames keep coming, so counts back up
  // and the block has to stall its input.
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_frame_size(11'd2, 11'd1);
    hold_cycles_left <= HOLD_CYCLES;
    send_values(40, SPREAD_LOW);
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    element_value_i  = '0;
    out_stall_i      = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = lmc_pkg::REG_FRAME_WIDTH;
    cfg_data_i       = '0;
    width_reg        = 11'd1;
    height_reg       = 11'd1;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_cycles_left = 0;
    cycle_count      = 0;
    mismatch_count   = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_size();
    test_directed_cases();
    test_size_clamping();
    test_random_frames();
    test_output_backpressure();

    drain_results();
    if (mismatch_count == 0 && expected_counts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
